FILE: design/qpp_pkg.sv
// Shared types, constants and register indexes of the quadrature position PID unit.
// No dependencies; every other design file imports this package.
package qpp_pkg;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 32;
  localparam int POS_W     = 32;
  localparam int ERR_W     = 33;
  localparam int DIFF_W    = 34;
  localparam int SUM_W     = 48;
  localparam int DUTY_W    = 7;

  // Multiplier operand split: a 32-bit low part and a signed high part
  localparam int OPND_W    = 48;
  localparam int LO_W      = 32;
  localparam int HI_W      = OPND_W - LO_W;

  // Accumulator wide enough for the exact three-term PID sum
  localparam int ACC_W     = 83;

  localparam int GAIN_FRAC_BITS = 24;
  localparam int DUTY_MAX       = 100;
  localparam int QUO_W          = ACC_W - GAIN_FRAC_BITS;

  // Bus widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Integral saturation limits
  localparam logic [SUM_W-1:0] SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

  // Event codes carried on the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_EDGE_A    = 3'd0,
    OP_EDGE_B    = 3'd1,
    OP_PID_TICK  = 3'd2,
    OP_FORCE_REV = 3'd3,
    OP_FORCE_FWD = 3'd4,
    OP_RESTART   = 3'd5
  } op_t;

  // What a pipeline slot will turn into at the output
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_REV,
    KIND_FWD,
    KIND_CLEAR
  } kind_t;

  // Gain register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_B = 3'd5;

  // Gain reset values
  localparam logic [GAIN_W-1:0] PROP_A_RST  = 32'd85181000;
  localparam logic [GAIN_W-1:0] INTEG_A_RST = 32'd0;
  localparam logic [GAIN_W-1:0] DERIV_A_RST = 32'd567880000;
  localparam logic [GAIN_W-1:0] PROP_B_RST  = 32'd220052000;
  localparam logic [GAIN_W-1:0] INTEG_B_RST = 32'd71;
  localparam logic [GAIN_W-1:0] DERIV_B_RST = 32'd638862000;

  // Load enables of the two multiplier stages
  typedef struct packed {
    logic s2;
    logic s3;
  } term_en_t;

endpackage

FILE: design/qpp_gain_term.sv
// One PID term: unsigned gain times a signed 48-bit operand, exact, over two stages.
// Depends on qpp_pkg.
module qpp_gain_term (
  input  logic                            clk,
  input  qpp_pkg::term_en_t               en,
  input  logic [qpp_pkg::GAIN_W-1:0]      gain,
  input  logic [qpp_pkg::OPND_W-1:0]      opnd,
  output logic [qpp_pkg::ACC_W-1:0]       term
);
  import qpp_pkg::*;

  logic signed [GAIN_W:0]        gain_s;
  logic signed [HI_W-1:0]        opnd_hi;
  logic        [2*LO_W-1:0]      lo_nxt;
  logic signed [GAIN_W+HI_W:0]   hi_nxt;
  logic        [2*LO_W-1:0]      lo_r;
  logic signed [GAIN_W+HI_W:0]   hi_r;
  logic        [ACC_W-1:0]       term_r;

  // Partial products: unsigned low word and signed high part of the operand.
  assign gain_s  = $signed({1'b0, gain});
  assign opnd_hi = $signed(opnd[OPND_W-1:LO_W]);
  assign lo_nxt  = gain * opnd[LO_W-1:0];
  assign hi_nxt  = gain_s * opnd_hi;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    // Recombine the partial products into one signed term.
    if (en.s3) begin
      term_r <= {{(ACC_W-2*LO_W){1'b0}}, lo_r}
              + {{(ACC_W-GAIN_W-HI_W-1-LO_W){hi_r[GAIN_W+HI_W]}}, hi_r, {LO_W{1'b0}}};
    end
  end

  assign term = term_r;

endmodule

FILE: design/quadrature_position_pid_unit.sv
// Top level of the quadrature position PID unit: encoder count, PID state and output pipeline.
// Depends on qpp_pkg and qpp_gain_term.
//
//  channel | ports                       | word contents (lowest bit first)
//  --------+-----------------------------+-------------------------------------------------
//  input   | in_tvalid/in_tready/tdata   | level_a, level_b, target_counts, gain_select
//          | in_tuser                    | opcode
//  output  | out_tvalid/out_tready/tdata | reverse_duty, forward_duty, position_now
//  config  | cfg_we/cfg_index/cfg_wdata  | one 32-bit gain per index
//
// One word is accepted per cycle while in_tready is high. A result is registered in turn in
// stage 1, the split gain multipliers, the sum, the magnitude stage and the output register.
// Edge words and unused codes update the count (or nothing) and produce no result.
// Synchronous active-low reset clears the count, PID state and all valid flags, and restores
// the gains to their reset values.
// Each stage moves when the stage after it is empty or moving, so bubbles close up under a
// stalled output and words are still taken while a finished result waits.
module quadrature_position_pid_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] level_a, [1] level_b, [33:2] target_counts, [34] gain_select, [39:35] zero
  input  logic [qpp_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] opcode
  input  logic [qpp_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [6:0] reverse_duty, [13:7] forward_duty, [45:14] position_now, [47:46] zero
  output logic [qpp_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [qpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qpp_pkg::GAIN_W-1:0]        cfg_wdata
);
  import qpp_pkg::*;

  // Gain registers
  logic [GAIN_W-1:0] prop_a_r, integ_a_r, deriv_a_r;
  logic [GAIN_W-1:0] prop_b_r, integ_b_r, deriv_b_r;

  // Loop state
  logic [POS_W-1:0] position_count_r, position_count_nxt;
  logic [ERR_W-1:0] last_error_r, last_error_nxt;
  logic [SUM_W-1:0] error_sum_r, error_sum_nxt;

  // Input word fields
  op_t              in_op;
  logic             in_level_a, in_level_b, in_gain_sel;
  logic [POS_W-1:0] in_target;
  logic             in_accept;

  // Combinational tick arithmetic
  logic [ERR_W-1:0]  err_now;
  logic [DIFF_W-1:0] diff_now;
  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_sat;
  logic              res_valid;
  kind_t             res_kind;

  // Stage ready chain
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  term_en_t term_en;

  // Stage 1
  logic              v1_r;
  kind_t             kind1_r;
  logic [POS_W-1:0]  pos1_r;
  logic [ERR_W-1:0]  err1_r;
  logic [DIFF_W-1:0] diff1_r;
  logic [SUM_W-1:0]  sum1_r;
  logic [GAIN_W-1:0] gp1_r, gi1_r, gd1_r;

  // Stages 2 to 5
  logic             v2_r, v3_r, v4_r, v5_r;
  kind_t            kind2_r, kind3_r, kind4_r, kind5_r;
  logic [POS_W-1:0] pos2_r, pos3_r, pos4_r, pos5_r;
  logic [ACC_W-1:0] term_p, term_i, term_d;
  logic [ACC_W-1:0] total4_r;
  logic [ACC_W-1:0] mag5_r;
  logic             neg5_r;

  // Output stage
  logic [QUO_W-1:0]      quo;
  logic [DUTY_W-1:0]     duty;
  logic [DUTY_W-1:0]     rev_nxt, fwd_nxt;
  logic                  out_valid_r;
  logic [DUTY_W-1:0]     rev_r, fwd_r;
  logic [POS_W-1:0]      pos_out_r;

  // Unpack the input word.
  assign in_op       = op_t'(in_tuser);
  assign in_level_a  = in_tdata[0];
  assign in_level_b  = in_tdata[1];
  assign in_target   = in_tdata[POS_W+1:2];
  assign in_gain_sel = in_tdata[POS_W+2];
  assign in_accept   = in_tvalid && in_tready;

  // Ready chain: a stage takes a word when empty or when its contents move on.
  assign rdy6 = !out_valid_r || out_tready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready  = rdy1;
  assign term_en.s2 = rdy2;
  assign term_en.s3 = rdy3;

  // Error, derivative difference and saturated integral for a tick.
  assign err_now  = {in_target[POS_W-1], in_target}
                  - {position_count_r[POS_W-1], position_count_r};
  assign diff_now = {err_now[ERR_W-1], err_now} - {last_error_r[ERR_W-1], last_error_r};
  assign sum_raw  = {error_sum_r[SUM_W-1], error_sum_r}
                  + {{(SUM_W+1-ERR_W){err_now[ERR_W-1]}}, err_now};

  always_comb begin
    if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
      sum_sat = sum_raw[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT;
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
  end

  // Event decode: state update and whether a result follows.
  always_comb begin
    position_count_nxt = position_count_r;
    last_error_nxt     = last_error_r;
    error_sum_nxt      = error_sum_r;
    res_valid          = 1'b0;
    res_kind           = KIND_TICK;
    unique case (in_op)
      OP_EDGE_A: begin
        position_count_nxt = (in_level_a == in_level_b) ? position_count_r + 1'b1
                                                        : position_count_r - 1'b1;
      end
      OP_EDGE_B: begin
        position_count_nxt = (in_level_a == in_level_b) ? position_count_r - 1'b1
                                                        : position_count_r + 1'b1;
      end
      OP_PID_TICK: begin
        last_error_nxt = err_now;
        error_sum_nxt  = sum_sat;
        res_valid      = 1'b1;
        res_kind       = KIND_TICK;
      end
      OP_FORCE_REV: begin
        res_valid = 1'b1;
        res_kind  = KIND_REV;
      end
      OP_FORCE_FWD: begin
        res_valid = 1'b1;
        res_kind  = KIND_FWD;
      end
      OP_RESTART: begin
        position_count_nxt = '0;
        last_error_nxt     = '0;
        error_sum_nxt      = '0;
        res_valid          = 1'b1;
        res_kind           = KIND_CLEAR;
      end
      default: begin
      end
    endcase
  end

  // Gain registers and loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_a_r         <= PROP_A_RST;
      integ_a_r        <= INTEG_A_RST;
      deriv_a_r        <= DERIV_A_RST;
      prop_b_r         <= PROP_B_RST;
      integ_b_r        <= INTEG_B_RST;
      deriv_b_r        <= DERIV_B_RST;
      position_count_r <= '0;
      last_error_r     <= '0;
      error_sum_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROP_A:  prop_a_r  <= cfg_wdata;
          CFG_INTEG_A: integ_a_r <= cfg_wdata;
          CFG_DERIV_A: deriv_a_r <= cfg_wdata;
          CFG_PROP_B:  prop_b_r  <= cfg_wdata;
          CFG_INTEG_B: integ_b_r <= cfg_wdata;
          CFG_DERIV_B: deriv_b_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        position_count_r <= position_count_nxt;
        last_error_r     <= last_error_nxt;
        error_sum_r      <= error_sum_nxt;
      end
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_accept && res_valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) v5_r        <= v4_r;
      if (rdy6) out_valid_r <= v5_r;
    end
  end

  // Stage 1: operands, selected gain set and recorded position.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r <= res_kind;
      pos1_r  <= position_count_nxt;
      err1_r  <= err_now;
      diff1_r <= diff_now;
      sum1_r  <= sum_sat;
      gp1_r   <= in_gain_sel ? prop_b_r  : prop_a_r;
      gi1_r   <= in_gain_sel ? integ_b_r : integ_a_r;
      gd1_r   <= in_gain_sel ? deriv_b_r : deriv_a_r;
    end
  end

  // Stages 2 and 3: the three gain products.
  qpp_gain_term u_term_p (
    .clk  (clk),
    .en   (term_en),
    .gain (gp1_r),
    .opnd ({{(OPND_W-ERR_W){err1_r[ERR_W-1]}}, err1_r}),
    .term (term_p)
  );

  qpp_gain_term u_term_d (
    .clk  (clk),
    .en   (term_en),
    .gain (gd1_r),
    .opnd ({{(OPND_W-DIFF_W){diff1_r[DIFF_W-1]}}, diff1_r}),
    .term (term_d)
  );

  qpp_gain_term u_term_i (
    .clk  (clk),
    .en   (term_en),
    .gain (gi1_r),
    .opnd (sum1_r),
    .term (term_i)
  );

  // Side payload alongside the multipliers, then sum, then magnitude.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      kind2_r <= kind1_r;
      pos2_r  <= pos1_r;
    end
    if (rdy3) begin
      kind3_r <= kind2_r;
      pos3_r  <= pos2_r;
    end
    if (rdy4) begin
      kind4_r  <= kind3_r;
      pos4_r   <= pos3_r;
      total4_r <= term_p + term_d + term_i;
    end
    if (rdy5) begin
      kind5_r <= kind4_r;
      pos5_r  <= pos4_r;
      neg5_r  <= total4_r[ACC_W-1];
      mag5_r  <= total4_r[ACC_W-1] ? (~total4_r + 1'b1) : total4_r;
    end
  end

  // Truncate to whole percent and saturate.
  assign quo  = mag5_r[ACC_W-1:GAIN_FRAC_BITS];
  assign duty = (quo > QUO_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : quo[DUTY_W-1:0];

  // Pin selection by result kind; a zero sum yields zero duty on both pins.
  always_comb begin
    rev_nxt = '0;
    fwd_nxt = '0;
    unique case (kind5_r)
      KIND_TICK: begin
        rev_nxt = neg5_r ? duty : '0;
        fwd_nxt = neg5_r ? '0 : duty;
      end
      KIND_REV:   rev_nxt = DUTY_W'(DUTY_MAX);
      KIND_FWD:   fwd_nxt = DUTY_W'(DUTY_MAX);
      KIND_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy6) begin
      rev_r     <= rev_nxt;
      fwd_r     <= fwd_nxt;
      pos_out_r <= pos5_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-POS_W-2*DUTY_W){1'b0}}, pos_out_r, fwd_r, rev_r};

  // A restart leaves all loop state cleared.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == OP_RESTART)
    |=> (position_count_r == '0) && (last_error_r == '0) && (error_sum_r == '0))
    else $error("restart did not clear the loop state");

  // Encoder edges never enter the result pipeline.
  a_edge_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && ((in_tuser == OP_EDGE_A) || (in_tuser == OP_EDGE_B)) |=> !v1_r)
    else $error("encoder edge produced a pipeline slot");

  // At most one motor pin is driven at a time.
  a_one_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rev_r == '0) || (fwd_r == '0))
    else $error("both motor pins driven");

  // Duty never exceeds the limit.
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rev_r <= DUTY_W'(DUTY_MAX)) && (fwd_r <= DUTY_W'(DUTY_MAX)))
    else $error("duty above limit");

endmodule

FILE: verif/tb_quadrature_position_pid_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for quadrature_position_pid_unit: encoder counting, PID duty and forcing.
// Depends on qpp_pkg and the design files; a built-in predictor supplies the expected words.
module tb_quadrature_position_pid_unit;
  import qpp_pkg::*;

  // Codes outside the defined event set, which the unit must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  // Register indexes past the last gain, which the unit must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam int RUN_TICKS    = 24;
  localparam int RETURN_TICKS = 24;
  localparam int SETTLE_CYCLES = 12;

  // One result word: reverse duty, forward duty and position
  typedef struct packed {
    logic [DUTY_W-1:0]       rev_duty;
    logic [DUTY_W-1:0]       fwd_duty;
    logic signed [POS_W-1:0] position;
  } drive_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic [OP_W-1:0]         in_tuser;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [GAIN_W-1:0]       cfg_wdata;

  // Predictor state and gain copies
  logic signed [POS_W-1:0] enc_position;
  logic signed [ERR_W-1:0] prev_error;
  logic signed [SUM_W-1:0] error_integral;
  logic [GAIN_W-1:0]       gain_reg [6];

  drive_result_t pending_results [$];
  int  mismatch_count = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;
  int  rx_hold = 0;

  quadrature_position_pid_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
      rx_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Each result word is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    drive_result_t want;
    drive_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.rev_duty = out_tdata[6:0];
      got.fwd_duty = out_tdata[13:7];
      got.position = out_tdata[45:14];
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word, reverse duty", -1, got.rev_duty);
      end else begin
        want = pending_results.pop_front();
        if (got.rev_duty != want.rev_duty)
          note_mismatch("reverse_duty", want.rev_duty, got.rev_duty);
        if (got.fwd_duty != want.fwd_duty)
          note_mismatch("forward_duty", want.fwd_duty, got.fwd_duty);
        if (got.position != want.position)
          note_mismatch("position_now", want.position, got.position);
      end
    end
  end

  // Duty from a positive PID sum: integer part, capped at full scale.
  function automatic logic [DUTY_W-1:0] duty_from_sum(input logic signed [95:0] mag);
    logic signed [95:0] whole;
    whole = mag >>> GAIN_FRAC_BITS;
    return (whole > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : whole[DUTY_W-1:0];
  endfunction

  // Advances the predicted controller by one accepted word and queues any result.
  task automatic predict_drive(input logic [OP_W-1:0] op, input logic lvl_a, input logic lvl_b,
                               input logic signed [POS_W-1:0] target, input logic gsel);
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [95:0]      kp, ki, kd, e96, d96, s96, acc;
    drive_result_t           res;
    bit                      has_result;
    res = '0;
    has_result = 1'b1;
    case (op)
      OP_EDGE_A: begin
        enc_position = (lvl_a == lvl_b) ? enc_position + 1 : enc_position - 1;
        has_result = 1'b0;
      end
      OP_EDGE_B: begin
        enc_position = (lvl_a == lvl_b) ? enc_position - 1 : enc_position + 1;
        has_result = 1'b0;
      end
      OP_PID_TICK: begin
        err = target - enc_position;
        sum_ext = error_integral + err;
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
          error_integral = sum_ext[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT;
        else
          error_integral = sum_ext[SUM_W-1:0];
        kp = gsel ? gain_reg[CFG_PROP_B] : gain_reg[CFG_PROP_A];
        ki = gsel ? gain_reg[CFG_INTEG_B] : gain_reg[CFG_INTEG_A];
        kd = gsel ? gain_reg[CFG_DERIV_B] : gain_reg[CFG_DERIV_A];
        e96 = err;
        d96 = e96 - prev_error;
        s96 = error_integral;
        acc = kp * e96 + kd * d96 + ki * s96;
        prev_error = err;
        if (acc > 0)
          res.fwd_duty = duty_from_sum(acc);
        else if (acc < 0)
          res.rev_duty = duty_from_sum(-acc);
      end
      OP_FORCE_REV: res.rev_duty = DUTY_W'(DUTY_MAX);
      OP_FORCE_FWD: res.fwd_duty = DUTY_W'(DUTY_MAX);
      OP_RESTART: begin
        enc_position = '0;
        prev_error = '0;
        error_integral = '0;
      end
      default: has_result = 1'b0;
    endcase
    if (has_result) begin
      res.position = enc_position;
      pending_results.push_back(res);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60)
      return 0;
    return (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Offers one word, waits for the handshake, then predicts it and maybe idles.
  task automatic send_word(input logic [OP_W-1:0] op, input logic lvl_a, input logic lvl_b,
                           input logic [POS_W-1:0] target, input logic gsel);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, gsel, target, lvl_b, lvl_a};
    do @(posedge clk); while (!in_tready);
    predict_drive(op, lvl_a, lvl_b, target, gsel);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted word has come out and the pipe is empty.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= CFG_DERIV_B)
      gain_reg[idx] = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_gains(input logic [GAIN_W-1:0] kp_a, input logic [GAIN_W-1:0] ki_a,
                             input logic [GAIN_W-1:0] kd_a, input logic [GAIN_W-1:0] kp_b,
                             input logic [GAIN_W-1:0] ki_b, input logic [GAIN_W-1:0] kd_b);
    settle_pipeline();
    write_gain(CFG_PROP_A, kp_a);
    write_gain(CFG_INTEG_A, ki_a);
    write_gain(CFG_DERIV_A, kd_a);
    write_gain(CFG_PROP_B, kp_b);
    write_gain(CFG_INTEG_B, ki_b);
    write_gain(CFG_DERIV_B, kd_b);
  endtask

  // Random word: ticks mostly aim near the current count so the duty is not always saturated.
  task automatic send_random_word();
    int r;
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] target;
    r = $urandom_range(0, 99);
    if (r < 22)      op = OP_EDGE_A;
    else if (r < 44) op = OP_EDGE_B;
    else if (r < 74) op = OP_PID_TICK;
    else if (r < 80) op = OP_FORCE_REV;
    else if (r < 86) op = OP_FORCE_FWD;
    else if (r < 91) op = OP_RESTART;
    else if (r < 96) op = OP_UNUSED_6;
    else             op = OP_UNUSED_7;
    r = $urandom_range(0, 99);
    if (r < 70)      target = enc_position + ($signed($urandom_range(0, 80)) - 40);
    else if (r < 85) target = $urandom;
    else if (r < 89) target = 32'h7FFF_FFFF;
    else if (r < 93) target = 32'h8000_0000;
    else             target = enc_position;
    send_word(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), target,
              1'($urandom_range(0, 1)));
  endtask

  // Random traffic with the idling pattern changed every hundred words.
  task automatic run_random_phase(input int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        mode = $urandom_range(0, 3);
        tx_gaps_on = (mode != 0);
        rx_stalls_on = (mode != 1);
      end
      if ($urandom_range(0, 99) == 0)
        settle_pipeline();
      send_random_word();
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Every event code, both encoder rules and target extremes, under the reset gains.
  task automatic test_event_decoding();
    send_word(OP_RESTART, 1'b0, 1'b0, 32'd0, 1'b0);
    send_word(OP_FORCE_REV, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_FORCE_FWD, 1'b0, 1'b1, 32'd0, 1'b0);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'd0, 1'b0);
    send_word(OP_EDGE_A, 1'b0, 1'b0, 32'd0, 1'b0);
    send_word(OP_EDGE_A, 1'b1, 1'b0, 32'd0, 1'b0);
    send_word(OP_EDGE_B, 1'b1, 1'b1, 32'd0, 1'b1);
    send_word(OP_EDGE_B, 1'b0, 1'b1, 32'd0, 1'b0);
    send_word(OP_EDGE_A, 1'b1, 1'b1, 32'd0, 1'b0);
    send_word(OP_UNUSED_6, 1'b1, 1'b0, 32'h5555_5555, 1'b1);
    send_word(OP_UNUSED_7, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'd2, 1'b0);
    send_word(OP_PID_TICK, 1'b1, 1'b0, -32'sd3, 1'b1);
    send_word(OP_PID_TICK, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1);
    send_word(OP_PID_TICK, 1'b1, 1'b1, 32'h8000_0000, 1'b0);
    send_word(OP_FORCE_REV, 1'b0, 1'b0, 32'd0, 1'b0);
    send_word(OP_RESTART, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'd5, 1'b1);
  endtask

  // All-zero gains give no drive; all-ones gains saturate in both directions.
  task automatic test_gain_limits();
    apply_gains('0, '0, '0, '0, '0, '0);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'd1000, 1'b0);
    send_word(OP_PID_TICK, 1'b0, 1'b0, -32'sd1000, 1'b1);
    apply_gains('1, '1, '1, '1, '1, '1);
    send_word(OP_RESTART, 1'b0, 1'b0, 32'd0, 1'b0);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'd1, 1'b0);
    send_word(OP_PID_TICK, 1'b0, 1'b0, -32'sd1, 1'b1);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1);
    send_word(OP_PID_TICK, 1'b0, 1'b0, 32'h8000_0000, 1'b0);
  endtask

  // Long runs of extreme errors with a unit integral gain only: the integral grows large in
  // each direction in turn and is then walked back, and the duty follows its integer part.
  task automatic test_integral_runs();
    apply_gains('0, 32'd1, '0, '0, 32'd1, '0);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    send_word(OP_RESTART, 1'b0, 1'b0, 32'd0, 1'b0);
    send_word(OP_EDGE_A, 1'b1, 1'b0, 32'd0, 1'b0);
    for (int i = 0; i < RUN_TICKS; i++)
      send_word(OP_PID_TICK, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'($urandom_range(0, 1)));
    for (int i = 0; i < RETURN_TICKS; i++)
      send_word(OP_PID_TICK, 1'b0, 1'b0, 32'h8000_0000, 1'($urandom_range(0, 1)));
    for (int i = 0; i < 8; i++)
      send_word(OP_PID_TICK, 1'b0, 1'b0, 32'sd50000 * i, 1'b0);
    send_word(OP_RESTART, 1'b0, 1'b0, 32'd0, 1'b1);
    for (int i = 0; i < RUN_TICKS; i++)
      send_word(OP_PID_TICK, 1'b0, 1'b0, 32'h8000_0000, 1'($urandom_range(0, 1)));
    for (int i = 0; i < RETURN_TICKS; i++)
      send_word(OP_PID_TICK, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'($urandom_range(0, 1)));
    for (int i = 0; i < 8; i++)
      send_word(OP_PID_TICK, 1'b0, 1'b0, -32'sd50000 * i, 1'b1);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Reset gains restored by writes; the spare register indexes must leave them untouched.
  task automatic test_traffic_reset_gains();
    apply_gains(PROP_A_RST, INTEG_A_RST, DERIV_A_RST, PROP_B_RST, INTEG_B_RST, DERIV_B_RST);
    write_gain(CFG_SPARE_6, $urandom);
    write_gain(CFG_SPARE_7, $urandom);
    run_random_phase(300);
  endtask

  // Moderate gains so that most duties land between the limits.
  task automatic test_traffic_tuned_gains();
    for (int s = 0; s < 3; s++) begin
      apply_gains($urandom_range(0, 1 << 28), $urandom_range(0, 1 << 16),
                  $urandom_range(0, 1 << 29), $urandom_range(0, 1 << 28),
                  $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 29));
      run_random_phase(220);
    end
  endtask

  // Full-range gains, including the largest integral gains.
  task automatic test_traffic_random_gains();
    apply_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random_phase(130);
    apply_gains($urandom_range(0, 1 << 24), '1, $urandom_range(0, 1 << 24),
                $urandom, '1, $urandom);
    run_random_phase(130);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    enc_position   = '0;
    prev_error     = '0;
    error_integral = '0;
    gain_reg[CFG_PROP_A]  = PROP_A_RST;
    gain_reg[CFG_INTEG_A] = INTEG_A_RST;
    gain_reg[CFG_DERIV_A] = DERIV_A_RST;
    gain_reg[CFG_PROP_B]  = PROP_B_RST;
    gain_reg[CFG_INTEG_B] = INTEG_B_RST;
    gain_reg[CFG_DERIV_B] = DERIV_B_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_event_decoding();
    test_gain_limits();
    test_integral_runs();
    test_traffic_reset_gains();
    test_traffic_tuned_gains();
    test_traffic_random_gains();

    settle_pipeline();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
